// File: sv/sorted_run_fence_lookup_assert.svh
// Assertion macros for the sorted run fence lookup block.
`ifndef SORTED_RUN_FENCE_LOOKUP_ASSERT_SVH
`define SORTED_RUN_FENCE_LOOKUP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define SFL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfl: same-cycle check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define SFL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfl: next-cycle check failed");
`else
`define SFL_ASSERT_IMPL(lbl, ante, cons)
`define SFL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: sv/sfl_pkg.sv
// Shared constants, codes and control structs for the sorted run fence lookup.
package sfl_pkg;

  localparam int CAPACITY = 1024;
  localparam int ENT_AW   = $clog2(CAPACITY);
  localparam int IDX_W    = ENT_AW + 1;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int PAGE_W   = 11;
  localparam int FUNC_W   = 2;

  localparam logic [PAGE_W-1:0] PAGE_RESET = PAGE_W'(64);

  // Request kinds carried on tuser
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POINT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RANGE = 2'd2;

  // Input tdata layout: position, key, key_high, value
  localparam int IN_POS_LSB   = 0;
  localparam int IN_KEY_LSB   = IN_POS_LSB + ENT_AW;
  localparam int IN_KHI_LSB   = IN_KEY_LSB + KEY_W;
  localparam int IN_VAL_LSB   = IN_KHI_LSB + KEY_W;
  localparam int IN_FIELDS_W  = IN_VAL_LSB + VAL_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

  // Output tdata layout: found, found_value, index_low, index_high
  localparam int OUT_FIELDS_W = 1 + VAL_W + 2 * IDX_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Search engine request and context
  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  min_key;
    logic [IDX_W-1:0]  fence_count;
    logic [IDX_W-1:0]  run_length;
    logic [PAGE_W-1:0] spacing;
  } loc_req_t;

  // Search engine result
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] index;
  } loc_rsp_t;

  // Fence build sweep status and fence memory write
  typedef struct packed {
    logic              fence_we;
    logic [ENT_AW-1:0] fence_addr;
    logic [KEY_W-1:0]  fence_data;
    logic              min_we;
    logic              done;
    logic [IDX_W-1:0]  fence_count;
  } bld_rsp_t;

endpackage

// File: sv/sfl_ram.sv
// Generic single-port synchronous RAM with registered read data.
module sfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/sfl_build.sv
// Fence build sweep: copies every spacing-th entry key into the fence memory.
module sfl_build (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sfl_pkg::IDX_W-1:0]  run_length,
  input  logic [sfl_pkg::PAGE_W-1:0] spacing,
  input  logic [sfl_pkg::KEY_W-1:0]  rd_data,
  output logic [sfl_pkg::ENT_AW-1:0] rd_addr,
  output sfl_pkg::bld_rsp_t          rsp
);
  import sfl_pkg::*;

  localparam logic B_IDLE = 1'b0;
  localparam logic B_RUN  = 1'b1;

  logic              state_r, state_nxt;
  logic [ENT_AW-1:0] addr_r, addr_nxt;
  logic [ENT_AW-1:0] fidx_r, fidx_nxt;
  logic [PAGE_W:0]   step_sum;

  // Next entry sampled for a fence
  assign step_sum = (PAGE_W+1)'(addr_r) + (PAGE_W+1)'(spacing);

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    fidx_nxt  = fidx_r;
    rsp       = '0;
    unique case (state_r)
      B_IDLE: begin
        if (start) begin
          addr_nxt  = '0;
          fidx_nxt  = '0;
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        // read data belongs to addr_r, issued last cycle
        rsp.fence_we   = 1'b1;
        rsp.fence_addr = fidx_r;
        rsp.fence_data = rd_data;
        rsp.min_we     = (fidx_r == '0);
        if (step_sum < (PAGE_W+1)'(run_length)) begin
          addr_nxt = step_sum[ENT_AW-1:0];
          fidx_nxt = fidx_r + ENT_AW'(1);
        end else begin
          rsp.done        = 1'b1;
          rsp.fence_count = IDX_W'(fidx_r) + IDX_W'(1);
          state_nxt       = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign rd_addr = addr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    fidx_r <= fidx_nxt;
  end

endmodule

// File: sv/sfl_locate.sv
// Two-phase search engine: upper bound over fences, then lower bound in the page.
module sfl_locate (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sfl_pkg::loc_req_t          req,
  input  logic [sfl_pkg::KEY_W-1:0]  fence_rd_data,
  input  logic [sfl_pkg::KEY_W-1:0]  entry_rd_data,
  output logic [sfl_pkg::ENT_AW-1:0] rd_addr,
  output sfl_pkg::loc_rsp_t          rsp
);
  import sfl_pkg::*;

  localparam logic [2:0] L_IDLE  = 3'd0;
  localparam logic [2:0] L_FENCE = 3'd1;
  localparam logic [2:0] L_MUL   = 3'd2;
  localparam logic [2:0] L_EINIT = 3'd3;
  localparam logic [2:0] L_ESTEP = 3'd4;
  localparam logic [2:0] L_FIN   = 3'd5;

  localparam int PROD_W = IDX_W + PAGE_W;

  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  lo_r, lo_nxt;
  logic [IDX_W-1:0]  hi_r, hi_nxt;
  logic [ENT_AW-1:0] mid_r, mid_nxt;
  logic              miss_r, miss_nxt;

  logic [IDX_W-1:0]  lo_t;
  logic [IDX_W-1:0]  hi_t;
  logic [PAGE_W:0]   end_t;
  logic [PROD_W-1:0] prod;

  // Midpoint of [a, b); always below b, so it fits an entry address
  function automatic logic [ENT_AW-1:0] mid_of(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ENT_AW:1];
  endfunction

  // Page start = (fence slot - 1) * spacing
  assign prod = PROD_W'(lo_r - IDX_W'(1)) * PROD_W'(req.spacing);

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    miss_nxt  = miss_r;
    lo_t      = lo_r;
    hi_t      = hi_r;
    end_t     = '0;
    unique case (state_r)
      L_IDLE: begin
        if (req.start) begin
          // empty run or key below the first fence: miss at index zero
          if (req.fence_count == '0 || req.key < req.min_key) begin
            miss_nxt  = 1'b1;
            state_nxt = L_FIN;
          end else begin
            miss_nxt  = 1'b0;
            lo_nxt    = '0;
            hi_nxt    = req.fence_count;
            mid_nxt   = mid_of('0, req.fence_count);
            state_nxt = L_FENCE;
          end
        end
      end
      L_FENCE: begin
        // upper bound: first fence above the key
        if (fence_rd_data <= req.key) begin
          lo_t = IDX_W'(mid_r) + IDX_W'(1);
        end else begin
          hi_t = IDX_W'(mid_r);
        end
        lo_nxt = lo_t;
        hi_nxt = hi_t;
        if (lo_t < hi_t) begin
          mid_nxt = mid_of(lo_t, hi_t);
        end else begin
          state_nxt = L_MUL;
        end
      end
      L_MUL: begin
        lo_nxt    = IDX_W'(prod);
        state_nxt = L_EINIT;
      end
      L_EINIT: begin
        // page end, clipped at the run length
        end_t = (PAGE_W+1)'(lo_r) + (PAGE_W+1)'(req.spacing);
        if (end_t > (PAGE_W+1)'(req.run_length)) begin
          end_t = (PAGE_W+1)'(req.run_length);
        end
        hi_t   = IDX_W'(end_t - (PAGE_W+1)'(1));
        hi_nxt = hi_t;
        if (lo_r < hi_t) begin
          mid_nxt   = mid_of(lo_r, hi_t);
          state_nxt = L_ESTEP;
        end else begin
          mid_nxt   = lo_r[ENT_AW-1:0];
          state_nxt = L_FIN;
        end
      end
      L_ESTEP: begin
        // lower bound inside the page
        if (req.key > entry_rd_data) begin
          lo_t = IDX_W'(mid_r) + IDX_W'(1);
        end else begin
          hi_t = IDX_W'(mid_r);
        end
        lo_nxt = lo_t;
        hi_nxt = hi_t;
        if (lo_t < hi_t) begin
          mid_nxt = mid_of(lo_t, hi_t);
        end else begin
          mid_nxt   = lo_t[ENT_AW-1:0];
          state_nxt = L_FIN;
        end
      end
      L_FIN: begin
        state_nxt = L_IDLE;
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  assign rd_addr = mid_nxt;

  // Entry at lo_r is on the read port while in L_FIN
  assign rsp.done  = (state_r == L_FIN);
  assign rsp.hit   = !miss_r && (entry_rd_data == req.key);
  assign rsp.index = miss_r ? '0 : lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    miss_r <= miss_nxt;
  end

endmodule

// File: sv/sorted_run_fence_lookup.sv
// Top level of the sorted run fence lookup: request control, memories, result register.
//
// Holds one sorted run of up to 1024 key/value entries in synchronous memories.
// Request stream (in_*): tuser selects load, point lookup or range lookup; tlast on
// a load marks the final entry and fixes the run length. Loads give no result.
// Result stream (out_*): one result per lookup, in request order.
// Configuration: cfg_we writes page_size; it is sampled by the final load.
// Flow: a plain load is written to the entry memories as it is accepted. A final
// load starts a fence build that reads one entry per cycle and holds in_tready low
// until the build is done. A point lookup makes one memory read per search step;
// a range lookup runs up to two such searches. One request is worked on at a time.
// The result sits in an output register, so the next request is accepted while
// out_tvalid waits for out_tready; a stalled receiver holds back only the next
// finished lookup. Reset empties the run: until a final load every lookup
// returns zeros, and page_size returns to 64. Entry memories are not cleared.
`include "sorted_run_fence_lookup_assert.svh"

module sorted_run_fence_lookup (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration: page_size
  input  logic                           cfg_we,
  input  logic [sfl_pkg::PAGE_W-1:0]     cfg_wdata,
  // request stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // tdata: position[9:0], key[41:10], key_high[73:42], value[105:74]
  input  logic [sfl_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: func[1:0]
  input  logic [sfl_pkg::FUNC_W-1:0]     in_tuser,
  // tlast: last_entry
  input  logic                           in_tlast,
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // tdata: found[0], found_value[32:1], index_low[43:33], index_high[54:44]
  output logic [sfl_pkg::OUT_DATA_W-1:0] out_tdata
);
  import sfl_pkg::*;

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_BUILD = 2'd1;
  localparam logic [1:0] T_LOOK  = 2'd2;
  localparam logic [1:0] T_FIN   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [PAGE_W-1:0] page_size_r;
  logic [PAGE_W-1:0] spacing_r;
  logic [IDX_W-1:0]  run_len_r;
  logic [IDX_W-1:0]  fence_cnt_r;
  logic [KEY_W-1:0]  min_key_r;
  logic [KEY_W-1:0]  max_key_r;
  logic              loc_go_r, loc_go_nxt;
  logic              bld_go_r, bld_go_nxt;
  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [FUNC_W-1:0] func_r;
  logic [KEY_W-1:0]  key_high_r;
  logic [KEY_W-1:0]  loc_key_r;
  logic              pass_r;
  logic              need_b_r;
  logic              res_found_r;
  logic [VAL_W-1:0]  res_value_r;
  logic [IDX_W-1:0]  res_ilo_r;
  logic [IDX_W-1:0]  res_ihi_r;

  logic [ENT_AW-1:0] in_pos;
  logic [KEY_W-1:0]  in_key;
  logic [KEY_W-1:0]  in_khi;
  logic [VAL_W-1:0]  in_val;
  logic              in_acc;
  logic              is_load, is_point, is_range;
  logic              range_ok, need_a, need_b;
  logic [IDX_W-1:0]  ihi_init;
  logic              out_load;

  logic              ent_we;
  logic [ENT_AW-1:0] ent_addr;
  logic [KEY_W-1:0]  ent_key_rd;
  logic [VAL_W-1:0]  ent_val_rd;
  logic [ENT_AW-1:0] fence_addr;
  logic [KEY_W-1:0]  fence_rd;

  loc_req_t          loc_req;
  loc_rsp_t          loc_rsp;
  logic [ENT_AW-1:0] loc_addr;
  bld_rsp_t          bld_rsp;
  logic [ENT_AW-1:0] bld_addr;

  // Request fields
  assign in_pos = in_tdata[IN_POS_LSB +: ENT_AW];
  assign in_key = in_tdata[IN_KEY_LSB +: KEY_W];
  assign in_khi = in_tdata[IN_KHI_LSB +: KEY_W];
  assign in_val = in_tdata[IN_VAL_LSB +: VAL_W];

  assign in_tready = (state_r == T_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_load   = (in_tuser == FUNC_LOAD);
  assign is_point  = (in_tuser == FUNC_POINT);
  assign is_range  = (in_tuser == FUNC_RANGE);

  // Range request classification against the run bounds
  assign range_ok = (run_len_r != '0) && !(in_khi < min_key_r || in_key > max_key_r);
  assign need_a   = is_point || (is_range && range_ok && in_key >= min_key_r);
  assign need_b   = is_range && range_ok && (in_khi < max_key_r);
  assign ihi_init = (is_range && range_ok && !(in_khi < max_key_r)) ? run_len_r : '0;

  assign out_load = (state_r == T_FIN) && (!out_valid_r || out_tready);

  // Memory port steering
  assign ent_we     = in_acc && is_load;
  assign ent_addr   = ent_we ? in_pos : ((state_r == T_BUILD) ? bld_addr : loc_addr);
  assign fence_addr = bld_rsp.fence_we ? bld_rsp.fence_addr : loc_addr;

  sfl_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (ent_we),
    .addr  (ent_addr),
    .wdata (in_key),
    .rdata (ent_key_rd)
  );

  sfl_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (ent_we),
    .addr  (ent_addr),
    .wdata (in_val),
    .rdata (ent_val_rd)
  );

  sfl_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_fence_ram (
    .clk   (clk),
    .we    (bld_rsp.fence_we),
    .addr  (fence_addr),
    .wdata (bld_rsp.fence_data),
    .rdata (fence_rd)
  );

  sfl_build u_build (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (bld_go_r),
    .run_length (run_len_r),
    .spacing    (spacing_r),
    .rd_data    (ent_key_rd),
    .rd_addr    (bld_addr),
    .rsp        (bld_rsp)
  );

  assign loc_req = '{start:       loc_go_r,
                     key:         loc_key_r,
                     min_key:     min_key_r,
                     fence_count: fence_cnt_r,
                     run_length:  run_len_r,
                     spacing:     spacing_r};

  sfl_locate u_locate (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (loc_req),
    .fence_rd_data (fence_rd),
    .entry_rd_data (ent_key_rd),
    .rd_addr       (loc_addr),
    .rsp           (loc_rsp)
  );

  // Control sequence
  always_comb begin
    state_nxt  = state_r;
    loc_go_nxt = 1'b0;
    bld_go_nxt = 1'b0;
    unique case (state_r)
      T_IDLE: begin
        if (in_acc) begin
          if (is_load && in_tlast) begin
            bld_go_nxt = 1'b1;
            state_nxt  = T_BUILD;
          end else if (need_a || need_b) begin
            loc_go_nxt = 1'b1;
            state_nxt  = T_LOOK;
          end else if (is_range) begin
            state_nxt = T_FIN;
          end
        end
      end
      T_BUILD: begin
        if (bld_rsp.done) begin
          state_nxt = T_IDLE;
        end
      end
      T_LOOK: begin
        if (loc_rsp.done) begin
          if (!pass_r && need_b_r) begin
            loc_go_nxt = 1'b1;
          end else begin
            state_nxt = T_FIN;
          end
        end
      end
      T_FIN: begin
        if (out_load) begin
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  // Control and run registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      page_size_r <= PAGE_RESET;
      spacing_r   <= PAGE_RESET;
      run_len_r   <= '0;
      fence_cnt_r <= '0;
      min_key_r   <= '0;
      max_key_r   <= '0;
      loc_go_r    <= 1'b0;
      bld_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      loc_go_r <= loc_go_nxt;
      bld_go_r <= bld_go_nxt;
      if (cfg_we) begin
        page_size_r <= cfg_wdata;
      end
      if (ent_we && in_tlast) begin
        run_len_r <= IDX_W'(in_pos) + IDX_W'(1);
        spacing_r <= (page_size_r == '0) ? PAGE_W'(1) : page_size_r;
        max_key_r <= in_key;
      end
      if (bld_rsp.min_we) begin
        min_key_r <= bld_rsp.fence_data;
      end
      if (bld_rsp.done) begin
        fence_cnt_r <= bld_rsp.fence_count;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Lookup working registers and result register
  always_ff @(posedge clk) begin
    if (in_acc && !is_load) begin
      func_r      <= in_tuser;
      key_high_r  <= in_khi;
      loc_key_r   <= need_a ? in_key : in_khi;
      pass_r      <= !need_a;
      need_b_r    <= need_a && need_b;
      res_found_r <= 1'b0;
      res_value_r <= '0;
      res_ilo_r   <= '0;
      res_ihi_r   <= ihi_init;
    end else if (state_r == T_LOOK && loc_rsp.done) begin
      if (!pass_r) begin
        res_ilo_r <= loc_rsp.index;
        if (func_r == FUNC_POINT) begin
          res_found_r <= loc_rsp.hit;
          res_value_r <= loc_rsp.hit ? ent_val_rd : '0;
        end
        if (need_b_r) begin
          loc_key_r <= key_high_r;
          pass_r    <= 1'b1;
        end
      end else begin
        res_ihi_r <= loc_rsp.index;
      end
    end
    if (out_load) begin
      out_data_r <= OUT_DATA_W'({res_ihi_r, res_ilo_r, res_value_r, res_found_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  `SFL_ASSERT_IMPL(a_loc_done_in_look, loc_rsp.done, state_r == T_LOOK)
  `SFL_ASSERT_IMPL(a_fence_we_in_build, bld_rsp.fence_we, state_r == T_BUILD)
  `SFL_ASSERT_IMPL(a_found_only_point, state_r == T_FIN && res_found_r, func_r == FUNC_POINT)
  `SFL_ASSERT_NEXT(a_build_has_fence, state_r == T_BUILD && bld_rsp.done, fence_cnt_r != '0)

endmodule
